// ----- rtl/tsse_pkg.sv -----
// Shared types and constants for the TLS server-name stream extractor.
package tsse_pkg;

   localparam int DEF_MAX_NAME    = 256;
   localparam int DEF_MAX_PAYLOAD = 65535;

   // fixed header checks
   localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
   localparam logic [7:0] REC_VERSION_MAJ = 8'h03;
   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam int         POS_REC_TYPE    = 0;
   localparam int         POS_REC_VER     = 1;
   localparam int         POS_HS_TYPE     = 5;
   localparam int         POS_SID_LEN     = 43;
   localparam int         SID_BASE        = 44;

   localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
   localparam logic [7:0]  SN_HOST_NAME    = 8'h00;
   localparam logic [15:0] SN_EXT_MIN_LEN  = 16'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       name_byte_valid;
      logic       verdict;
      logic       found;
      logic [7:0] name_length;
   } rsp_type;

   // handshake between the stages
   typedef struct packed {
      logic step;      // input word moves through the parser this cycle
   } flow_type;

endpackage

// ----- rtl/tsse_in_stage.sv -----
// Input register of the extractor.
module tsse_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tsse_pkg::req_type req_data,
   input  tsse_pkg::flow_type flow,
   output logic              item_valid,
   output tsse_pkg::req_type item
);
   import tsse_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || flow.step;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !flow.step);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// ----- rtl/tsse_parser.sv -----
// ClientHello walk: parse state registers and the per-byte next-state logic.
module tsse_parser #(
   parameter int MAX_NAME    = tsse_pkg::DEF_MAX_NAME,
   parameter int MAX_PAYLOAD = tsse_pkg::DEF_MAX_PAYLOAD
) (
   input  logic               clock,
   input  logic               reset,
   input  tsse_pkg::flow_type flow,
   input  tsse_pkg::req_type  item,
   output logic               res_valid,
   output tsse_pkg::rsp_type  res
);
   import tsse_pkg::*;

   localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
   localparam int TGT_W = $clog2(MAX_PAYLOAD + 65536);
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_PAYLOAD);
   localparam logic [15:0]      NAME_LIM = 16'(MAX_NAME);

   typedef enum logic [16:0] {
      PH_HDR       = 17'b00000000000000001,
      PH_SID       = 17'b00000000000000010,
      PH_CS_LO     = 17'b00000000000000100,
      PH_CS_SKIP   = 17'b00000000000001000,
      PH_CM_SKIP   = 17'b00000000000010000,
      PH_EXTLEN_LO = 17'b00000000000100000,
      PH_EXT_SKIP  = 17'b00000000001000000,
      PH_TYPE_LO   = 17'b00000000010000000,
      PH_LEN_HI    = 17'b00000000100000000,
      PH_LEN_LO    = 17'b00000001000000000,
      PH_SN_LIST   = 17'b00000010000000000,
      PH_NAME_HI   = 17'b00000100000000000,
      PH_NAME_LO   = 17'b00001000000000000,
      PH_NAME      = 17'b00010000000000000,
      PH_WAIT      = 17'b00100000000000000,
      PH_DONE      = 17'b01000000000000000,
      PH_FAIL      = 17'b10000000000000000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [TGT_W-1:0] skip_ff, skip_in;
   logic [TGT_W-1:0] blk_end_ff, blk_end_in;
   logic [15:0]      ext_type_ff, ext_type_in;
   logic [TGT_W-1:0] ext_end_ff, ext_end_in;
   logic [15:0]      hnl_ff, hnl_in;
   logic             vg_ff, vg_in;

   logic [7:0]       b;
   logic             last;
   logic [TGT_W-1:0] pe, p1;
   logic [15:0]      n16;
   logic [TGT_W-1:0] tgt;
   logic             emit, found;

   assign b    = item.data_byte;
   assign last = item.end_of_payload;

   always_comb begin
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      blk_end_in  = blk_end_ff;
      ext_type_in = ext_type_ff;
      ext_end_in  = ext_end_ff;
      hnl_in      = hnl_ff;
      vg_in       = vg_ff;
      emit        = 1'b0;
      found       = 1'b0;
      pe          = TGT_W'(pos_ff);
      p1          = pe + TGT_W'(1);
      n16         = hnl_ff | {8'h00, b};
      tgt         = p1 + TGT_W'(n16);

      if (phase_ff != PH_DONE && phase_ff != PH_FAIL && pos_ff >= POS_MAX) begin
         phase_in = PH_FAIL;
      end else begin
         unique case (phase_ff)
            PH_HDR: begin
               if ((pos_ff == POS_W'(POS_REC_TYPE) && b != REC_HANDSHAKE) ||
                   (pos_ff == POS_W'(POS_REC_VER) && b != REC_VERSION_MAJ) ||
                   (pos_ff == POS_W'(POS_HS_TYPE) && b != HS_CLIENT_HELLO)) begin
                  phase_in = PH_FAIL;
               end else if (pos_ff == POS_W'(POS_SID_LEN)) begin
                  skip_in  = TGT_W'(SID_BASE) + TGT_W'(b);
                  phase_in = PH_SID;
               end
            end
            PH_SID: begin
               if (pe >= skip_ff) begin
                  hnl_in   = {b, 8'h00};
                  phase_in = PH_CS_LO;
               end
            end
            PH_CS_LO: begin
               skip_in  = tgt;
               phase_in = PH_CS_SKIP;
            end
            PH_CS_SKIP: begin
               if (pe >= skip_ff) begin
                  skip_in  = p1 + TGT_W'(b);
                  phase_in = PH_CM_SKIP;
               end
            end
            PH_CM_SKIP: begin
               if (pe >= skip_ff) begin
                  hnl_in   = {b, 8'h00};
                  phase_in = PH_EXTLEN_LO;
               end
            end
            PH_EXTLEN_LO: begin
               blk_end_in = tgt;
               skip_in    = p1;
               phase_in   = PH_EXT_SKIP;
            end
            PH_EXT_SKIP: begin
               if (pe >= skip_ff) begin
                  // whole extension header must sit inside the block
                  if (pe + TGT_W'(4) > blk_end_ff) begin
                     phase_in = PH_FAIL;
                  end else begin
                     ext_type_in = {b, 8'h00};
                     phase_in    = PH_TYPE_LO;
                  end
               end
            end
            PH_TYPE_LO: begin
               ext_type_in = ext_type_ff | {8'h00, b};
               phase_in    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               hnl_in   = {b, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               ext_end_in = tgt;
               if (tgt > blk_end_ff) begin
                  phase_in = PH_FAIL;
               end else if (ext_type_ff == EXT_SERVER_NAME) begin
                  if (n16 < SN_EXT_MIN_LEN) begin
                     phase_in = PH_FAIL;
                  end else begin
                     skip_in  = pe + TGT_W'(3);
                     phase_in = PH_SN_LIST;
                  end
               end else begin
                  skip_in  = tgt;
                  phase_in = PH_EXT_SKIP;
               end
            end
            PH_SN_LIST: begin
               if (pe >= skip_ff) begin
                  phase_in = (b == SN_HOST_NAME) ? PH_NAME_HI : PH_FAIL;
               end
            end
            PH_NAME_HI: begin
               hnl_in   = {b, 8'h00};
               phase_in = PH_NAME_LO;
            end
            PH_NAME_LO: begin
               hnl_in  = n16;
               skip_in = tgt;
               if (tgt > blk_end_ff || n16 >= NAME_LIM) begin
                  phase_in = PH_FAIL;
               end else if (n16 == 16'h0000) begin
                  // empty name: skip target is p+1, only the extension end matters
                  if (p1 >= ext_end_ff) begin
                     phase_in = PH_DONE;
                     vg_in    = 1'b1;
                     found    = 1'b1;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end else begin
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               emit = pe < skip_ff;
               if (p1 >= skip_ff) begin
                  if (p1 >= ext_end_ff) begin
                     phase_in = PH_DONE;
                     vg_in    = 1'b1;
                     found    = 1'b1;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
            end
            PH_WAIT: begin
               if (p1 >= skip_ff && p1 >= ext_end_ff) begin
                  phase_in = PH_DONE;
                  vg_in    = 1'b1;
                  found    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
   end

   // result word for this byte
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      if (found) begin
         res_valid           = 1'b1;
         res.name_byte       = emit ? b : 8'h00;
         res.name_byte_valid = emit;
         res.verdict         = 1'b1;
         res.found           = 1'b1;
         res.name_length     = hnl_in[7:0];
      end else if (last) begin
         res_valid   = !vg_ff;
         res.verdict = 1'b1;
      end else if (emit) begin
         res_valid           = 1'b1;
         res.name_byte       = b;
         res.name_byte_valid = 1'b1;
      end
   end

   // end of payload rearms the parser
   always_ff @(posedge clock) begin
      if (reset || (flow.step && last)) begin
         phase_ff    <= PH_HDR;
         pos_ff      <= '0;
         skip_ff     <= '0;
         blk_end_ff  <= '0;
         ext_type_ff <= '0;
         ext_end_ff  <= '0;
         hnl_ff      <= '0;
         vg_ff       <= 1'b0;
      end else if (flow.step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         blk_end_ff  <= blk_end_in;
         ext_type_ff <= ext_type_in;
         ext_end_ff  <= ext_end_in;
         hnl_ff      <= hnl_in;
         vg_ff       <= vg_in;
      end
   end

endmodule

// ----- rtl/tsse_out_stage.sv -----
// Result register of the extractor.
module tsse_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  tsse_pkg::flow_type flow,
   input  logic              res_valid,
   input  tsse_pkg::rsp_type res,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsse_pkg::rsp_type rsp_data
);
   import tsse_pkg::*;

   logic    valid_ff, valid_in;
   logic    load;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = flow.step && res_valid;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/tls_sni_stream_extractor_top.sv -----
// Top level of the streaming TLS ClientHello server-name extractor.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_ready  req_data  (payload byte, end flag)
//   rsp_     out        rsp_valid/rsp_ready  rsp_data  (name byte, verdict)
//
// One payload byte per cycle while rsp_ is not stalled. A byte is held in the
// input register, is parsed on its way into the result register, and its word
// (if any) then shows on rsp_. Reset is synchronous and clears the parse
// state and both valid flags. A stalled rsp_ holds the byte in the input
// register; req_ready drops only when both registers are full.
module tls_sni_stream_extractor_top #(
   parameter int MAX_NAME    = tsse_pkg::DEF_MAX_NAME,
   parameter int MAX_PAYLOAD = tsse_pkg::DEF_MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tsse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsse_pkg::rsp_type rsp_data
);
   import tsse_pkg::*;

   flow_type flow;
   logic     item_valid;
   req_type  item;
   logic     res_valid;
   rsp_type  res;
   logic     out_free;

   assign flow.step = item_valid && out_free;

   tsse_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .flow       (flow),
      .item_valid (item_valid),
      .item       (item)
   );

   tsse_parser #(
      .MAX_NAME    (MAX_NAME),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   tsse_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/tb.sv -----
// Testbench for the TLS server-name stream extractor: directed rows, built hellos, random.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsse_pkg::*;

   localparam int NAME_LIMIT    = DEF_MAX_NAME;
   localparam int PAYLOAD_LIMIT = DEF_MAX_PAYLOAD;
   localparam int RANDOM_WORDS  = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;

   typedef enum logic [4:0] {
      PH_HELLO_HDR, PH_SESSION_ID, PH_SUITES_LO, PH_SUITES_SKIP, PH_COMP_SKIP,
      PH_EXTS_LO, PH_EXT_WALK, PH_EXT_TYPE_LO, PH_EXT_LEN_HI, PH_EXT_LEN_LO,
      PH_SN_LIST, PH_NAME_HI, PH_NAME_LO, PH_NAME_BYTES, PH_EXT_TAIL,
      PH_DONE, PH_FAILED
   } sni_phase_type;

   // how the word driven on a table row is checked
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_NO_SNI} check_type;

   typedef enum int {
      HELLO_OK, HELLO_NO_SNI, HELLO_HDR_SPLIT, HELLO_EXT_OVER, HELLO_SHORT_SN,
      HELLO_BAD_TYPE, HELLO_NAME_OVER, HELLO_NAME_LONG, HELLO_BAD_HDR
   } hello_kind_type;

   typedef logic [7:0] octet_q_type[$];

   typedef struct {
      logic [7:0] octet;
      bit         last;
      check_type  how;
   } hello_step_type;

   localparam rsp_type NOT_FOUND = rsp_type'{8'h00, 1'b0, 1'b1, 1'b0, 8'h00};

   const hello_step_type HELLO_STEPS[19] = '{
      '{8'h00,           1'b1, CHK_NO_SNI},
      '{8'hFF,           1'b1, CHK_NO_SNI},
      '{REC_HANDSHAKE,   1'b1, CHK_NO_SNI},
      '{REC_HANDSHAKE,   1'b0, CHK_SILENT},
      '{REC_VERSION_MAJ, 1'b0, CHK_MODEL},
      '{8'h00,           1'b0, CHK_MODEL},
      '{8'h00,           1'b0, CHK_MODEL},
      '{8'hFF,           1'b0, CHK_MODEL},
      '{8'h02,           1'b1, CHK_NO_SNI},
      '{REC_HANDSHAKE,   1'b0, CHK_SILENT},
      '{8'h04,           1'b0, CHK_SILENT},
      '{REC_HANDSHAKE,   1'b0, CHK_SILENT},
      '{8'hFF,           1'b1, CHK_NO_SNI},
      '{REC_HANDSHAKE,   1'b0, CHK_SILENT},
      '{REC_VERSION_MAJ, 1'b0, CHK_SILENT},
      '{8'hAA,           1'b0, CHK_MODEL},
      '{8'h55,           1'b0, CHK_MODEL},
      '{8'h00,           1'b0, CHK_MODEL},
      '{HS_CLIENT_HELLO, 1'b1, CHK_NO_SNI}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   tls_sni_stream_extractor_top #(
      .MAX_NAME(NAME_LIMIT),
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5ns clock = ~clock;

   // parser copy
   sni_phase_type phase;
   logic [16:0]   pos;
   logic [17:0]   skip_to;
   logic [17:0]   block_end;
   logic [15:0]   ext_kind;
   logic [17:0]   ext_end;
   logic [15:0]   len_acc;
   bit            answered;

   rsp_type     sni_words_due[$];
   check_type   word_checks[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          random_words = 0;
   int          ready_mode = 0;
   int          ready_run = 0;
   octet_q_type hello;

   function automatic void clear_parse();
      phase     = PH_HELLO_HDR;
      pos       = '0;
      skip_to   = '0;
      block_end = '0;
      ext_kind  = '0;
      ext_end   = '0;
      len_acc   = '0;
      answered  = 1'b0;
   endfunction

   function automatic bit name_complete(input logic [17:0] next);
      if (next >= skip_to && next >= ext_end) begin
         phase    = PH_DONE;
         answered = 1'b1;
         return 1'b1;
      end
      phase = PH_EXT_TAIL;
      return 1'b0;
   endfunction

   // advances the parser by one payload byte; returns 1 with the word it causes
   function automatic bit parse_byte(input req_type w, output rsp_type r);
      logic [7:0]  b;
      logic [17:0] p;
      logic [15:0] n;
      bit          emit;
      bit          hit;
      bit          need;
      b    = w.data_byte;
      p    = 18'(pos);
      emit = 1'b0;
      hit  = 1'b0;
      r    = '0;
      if (phase != PH_DONE && phase != PH_FAILED && p >= 18'(PAYLOAD_LIMIT)) begin
         phase = PH_FAILED;
      end else begin
         case (phase)
            PH_HELLO_HDR: begin
               if ((p == 18'(POS_REC_TYPE) && b != REC_HANDSHAKE) ||
                   (p == 18'(POS_REC_VER) && b != REC_VERSION_MAJ) ||
                   (p == 18'(POS_HS_TYPE) && b != HS_CLIENT_HELLO))
                  phase = PH_FAILED;
               else if (p == 18'(POS_SID_LEN)) begin
                  skip_to = 18'(SID_BASE) + 18'(b);
                  phase   = PH_SESSION_ID;
               end
            end
            PH_SESSION_ID: begin
               if (p >= skip_to) begin
                  len_acc = {b, 8'h00};
                  phase   = PH_SUITES_LO;
               end
            end
            PH_SUITES_LO: begin
               skip_to = p + 18'd1 + 18'({len_acc[15:8], b});
               phase   = PH_SUITES_SKIP;
            end
            PH_SUITES_SKIP: begin
               if (p >= skip_to) begin
                  skip_to = p + 18'd1 + 18'(b);
                  phase   = PH_COMP_SKIP;
               end
            end
            PH_COMP_SKIP: begin
               if (p >= skip_to) begin
                  len_acc = {b, 8'h00};
                  phase   = PH_EXTS_LO;
               end
            end
            PH_EXTS_LO: begin
               block_end = p + 18'd1 + 18'({len_acc[15:8], b});
               skip_to   = p + 18'd1;
               phase     = PH_EXT_WALK;
            end
            PH_EXT_WALK: begin
               if (p >= skip_to) begin
                  if (p + 18'd4 > block_end)
                     phase = PH_FAILED;
                  else begin
                     ext_kind = {b, 8'h00};
                     phase    = PH_EXT_TYPE_LO;
                  end
               end
            end
            PH_EXT_TYPE_LO: begin
               ext_kind = {ext_kind[15:8], b};
               phase    = PH_EXT_LEN_HI;
            end
            PH_EXT_LEN_HI: begin
               len_acc = {b, 8'h00};
               phase   = PH_EXT_LEN_LO;
            end
            PH_EXT_LEN_LO: begin
               n       = {len_acc[15:8], b};
               ext_end = p + 18'd1 + 18'(n);
               if (ext_end > block_end)
                  phase = PH_FAILED;
               else if (ext_kind == EXT_SERVER_NAME) begin
                  if (n < SN_EXT_MIN_LEN)
                     phase = PH_FAILED;
                  else begin
                     skip_to = p + 18'd3;
                     phase   = PH_SN_LIST;
                  end
               end else begin
                  skip_to = ext_end;
                  phase   = PH_EXT_WALK;
               end
            end
            PH_SN_LIST: begin
               if (p >= skip_to)
                  phase = (b == SN_HOST_NAME) ? PH_NAME_HI : PH_FAILED;
            end
            PH_NAME_HI: begin
               len_acc = {b, 8'h00};
               phase   = PH_NAME_LO;
            end
            PH_NAME_LO: begin
               n       = {len_acc[15:8], b};
               len_acc = n;
               skip_to = p + 18'd1 + 18'(n);
               if (skip_to > block_end || n >= 16'(NAME_LIMIT))
                  phase = PH_FAILED;
               else if (n == 16'h0000)
                  hit = name_complete(p + 18'd1);
               else
                  phase = PH_NAME_BYTES;
            end
            PH_NAME_BYTES: begin
               if (p < skip_to)
                  emit = 1'b1;
               if (p + 18'd1 >= skip_to)
                  hit = name_complete(p + 18'd1);
            end
            PH_EXT_TAIL: hit = name_complete(p + 18'd1);
            default: ;
         endcase
      end
      pos = (p < 18'(PAYLOAD_LIMIT)) ? 17'(p + 18'd1) : 17'(PAYLOAD_LIMIT);

      if (hit) begin
         r.name_byte       = emit ? b : 8'h00;
         r.name_byte_valid = emit;
         r.verdict         = 1'b1;
         r.found           = 1'b1;
         r.name_length     = len_acc[7:0];
         if (w.end_of_payload)
            clear_parse();
         return 1'b1;
      end
      if (w.end_of_payload) begin
         need = !answered;
         clear_parse();
         if (need) begin
            r.verdict = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      end
      if (emit) begin
         r.name_byte       = b;
         r.name_byte_valid = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void match_field(input string field, input int want, input int seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", field, want, seen);
         mismatches++;
      end
   endfunction

   function automatic void put16(ref octet_q_type q, input int v);
      q.push_back(8'(v >> 8));
      q.push_back(8'(v));
   endfunction

   function automatic void add_random(ref octet_q_type q, input int count);
      repeat (count) q.push_back(8'($urandom));
   endfunction

   // ClientHello whose SNI extension is shaped, or left out, by kind
   function automatic void build_hello(input hello_kind_type kind, input int host_len,
                                       input int pad, input bit trail, ref octet_q_type pkt);
      octet_q_type exts;
      octet_q_type body;
      int          sid_len;
      int          ext_len;
      int          block_len;
      pkt = {};
      exts = {};
      body = {};
      add_random(pkt, POS_SID_LEN);
      pkt[POS_REC_TYPE] = REC_HANDSHAKE;
      pkt[POS_REC_VER]  = REC_VERSION_MAJ;
      pkt[POS_HS_TYPE]  = HS_CLIENT_HELLO;
      sid_len = ($urandom_range(0, 15) == 0) ? 255 : int'($urandom_range(0, 6));
      pkt.push_back(8'(sid_len));
      add_random(pkt, sid_len);
      ext_len = int'($urandom_range(0, 8));
      put16(pkt, ext_len);
      add_random(pkt, ext_len);
      ext_len = int'($urandom_range(0, 3));
      pkt.push_back(8'(ext_len));
      add_random(pkt, ext_len);

      repeat ($urandom_range(0, 2)) begin
         ext_len = int'($urandom_range(0, 6));
         put16(exts, int'($urandom_range(1, 16'hFFFF)));
         put16(exts, ext_len);
         add_random(exts, ext_len);
      end

      if (kind == HELLO_SHORT_SN)
         add_random(body, int'($urandom_range(0, int'(SN_EXT_MIN_LEN) - 1)));
      else begin
         put16(body, host_len + 3);
         body.push_back((kind == HELLO_BAD_TYPE) ? 8'($urandom_range(1, 255)) : SN_HOST_NAME);
         put16(body, (kind == HELLO_NAME_OVER) ?
                        host_len + pad + int'($urandom_range(1, 20)) : host_len);
         add_random(body, host_len + pad);
      end
      if (kind == HELLO_HDR_SPLIT)
         add_random(exts, int'($urandom_range(1, 3)));
      else if (kind != HELLO_NO_SNI) begin
         put16(exts, int'(EXT_SERVER_NAME));
         put16(exts, body.size());
         exts = {exts, body};
      end
      // extension after the name: bytes past a found verdict
      if (kind == HELLO_OK && trail) begin
         ext_len = int'($urandom_range(0, 6));
         put16(exts, int'($urandom_range(0, 16'hFFFF)));
         put16(exts, ext_len);
         add_random(exts, ext_len);
      end

      block_len = exts.size();
      if (kind == HELLO_EXT_OVER)
         block_len -= int'($urandom_range(1, body.size()));
      put16(pkt, block_len);
      pkt = {pkt, exts};

      if (kind == HELLO_BAD_HDR) begin
         case ($urandom_range(0, 2))
            0: pkt[POS_REC_TYPE] ^= 8'($urandom_range(1, 255));
            1: pkt[POS_REC_VER]  ^= 8'($urandom_range(1, 255));
            default: pkt[POS_HS_TYPE] ^= 8'($urandom_range(1, 255));
         endcase
      end
   endfunction

   // called at a falling edge; returns at a falling edge once the word is taken
   task automatic send_word(input req_type w, input check_type how);
      int gap;
      word_checks.push_back(how);
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0)
         burst_left--;
      else begin
         burst_left = int'($urandom_range(0, 47));
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_packet(input octet_q_type pkt);
      foreach (pkt[k])
         send_word(req_type'{pkt[k], (k == pkt.size() - 1)}, CHK_MODEL);
   endtask

   // receiver: runs of always-ready, coin-flip, periodic hiccups and heavy stalls
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode <= int'($urandom_range(0, 3));
         ready_run  <= int'($urandom_range(16, 96));
      end else
         ready_run <= ready_run - 1;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= (ready_run % 4 != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   rsp_type   predicted;
   rsp_type   want;
   check_type taken_how;

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         sni_words_due.delete();
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            taken_how = word_checks.pop_front();
            if (parse_byte(req_data, predicted) && taken_how == CHK_MODEL)
               sni_words_due.push_back(predicted);
            if (taken_how == CHK_NO_SNI)
               sni_words_due.push_back(NOT_FOUND);
         end
         if (rsp_valid && rsp_ready) begin
            if (sni_words_due.size() == 0) begin
               $error("unexpected word: %p", rsp_data);
               mismatches++;
            end else begin
               want = sni_words_due.pop_front();
               match_field("name_byte", int'(want.name_byte), int'(rsp_data.name_byte));
               match_field("name_byte_valid", int'(want.name_byte_valid),
                           int'(rsp_data.name_byte_valid));
               match_field("verdict", int'(want.verdict), int'(rsp_data.verdict));
               match_field("found", int'(want.found), int'(rsp_data.found));
               match_field("name_length", int'(want.name_length),
                           int'(rsp_data.name_length));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fork
         begin
            foreach (HELLO_STEPS[k])
               send_word(req_type'{HELLO_STEPS[k].octet, HELLO_STEPS[k].last},
                         HELLO_STEPS[k].how);

            build_hello(HELLO_OK, 1, 0, 1'b0, hello);
            send_packet(hello);
            build_hello(HELLO_OK, 0, 0, 1'b1, hello);
            send_packet(hello);
            build_hello(HELLO_OK, NAME_LIMIT - 1, 0, 1'b0, hello);
            send_packet(hello);
            // extension longer than the name: verdict waits for its end
            build_hello(HELLO_OK, 5, 3, 1'b1, hello);
            send_packet(hello);
            for (int k = int'(HELLO_NO_SNI); k <= int'(HELLO_BAD_HDR); k++) begin
               build_hello(hello_kind_type'(k), (k == int'(HELLO_NAME_LONG)) ? NAME_LIMIT : 6,
                           0, 1'b0, hello);
               send_packet(hello);
            end
            // payload ends in the middle of the name
            build_hello(HELLO_OK, 8, 0, 1'b0, hello);
            hello = hello[0:hello.size() - 4];
            send_packet(hello);

            while (random_words < RANDOM_WORDS) begin
               case ($urandom_range(0, 9))
                  0: begin
                     hello = {};
                     add_random(hello, int'($urandom_range(1, 60)));
                     if ($urandom_range(0, 1) == 1)
                        hello[0] = REC_HANDSHAKE;
                  end
                  1, 2, 3: build_hello(hello_kind_type'($urandom_range(int'(HELLO_NO_SNI),
                                                                       int'(HELLO_BAD_HDR))),
                                       int'($urandom_range(0, 20)) +
                                          ($urandom_range(0, 1) == 1 ? NAME_LIMIT : 0),
                                       int'($urandom_range(0, 2)), 1'b0, hello);
                  default: build_hello(HELLO_OK,
                                       ($urandom_range(0, 15) == 0) ?
                                          int'($urandom_range(200, NAME_LIMIT - 1)) :
                                          int'($urandom_range(0, 24)),
                                       ($urandom_range(0, 1) == 1) ?
                                          int'($urandom_range(1, 4)) : 0,
                                       $urandom_range(0, 2) == 0, hello);
               endcase
               if (hello.size() > 1 && $urandom_range(0, 7) == 0)
                  hello = hello[0:$urandom_range(0, hello.size() - 2)];
               random_words += hello.size();
               send_packet(hello);
            end
            req_valid <= 1'b0;

            while (sni_words_due.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         wait (idle_cycles >= STALL_LIMIT);
      join_any

      if (idle_cycles >= STALL_LIMIT) begin
         $error("no word moved for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
      end else if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tsse_pkg.sv
rtl/tsse_in_stage.sv
rtl/tsse_parser.sv
rtl/tsse_out_stage.sv
rtl/tls_sni_stream_extractor_top.sv
test/tb.sv
